// ===== src/mds_pkg.sv =====
// shared types, constants and helper functions for the mipmap downsampler
`timescale 1ns / 1ps
package mds_pkg;

   localparam int NUM_CH    = 3;
   localparam int CH_W      = 24;
   localparam int CSR_W     = 4;
   localparam int KERN_N    = 4;
   localparam int WIN_COLS  = KERN_N - 1;
   localparam int LINE_ROWS = 3;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam int DEFAULT_MAX_SOURCE_SIZE = 256;
   localparam logic [CSR_W-1:0] SIZE_LOG2_RESET = 4'd8;

   // widths along the filter datapath
   localparam int PART_W      = CH_W + 1;
   localparam int SUM_W       = CH_W + 2;
   localparam int ACC_W       = 30;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 36;
   localparam int PROD_W      = ACC_W + RECIP_W;
   localparam int HALF_W      = 6;

   // remaining kernel weight after edge taps are dropped
   typedef logic [1:0] den_code_type;
   localparam den_code_type DEN_40 = 2'd0;
   localparam den_code_type DEN_34 = 2'd1;
   localparam den_code_type DEN_29 = 2'd2;
   localparam den_code_type DEN_20 = 2'd3;

   localparam int DIV_40 = 40;
   localparam int DIV_34 = 34;
   localparam int DIV_29 = 29;
   localparam int DIV_20 = 20;

   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   // ceil(2^36 / d): exact quotient for any dividend below 2^30
   localparam logic [RECIP_W-1:0] RECIP_40 =
      RECIP_W'((RECIP_ONE + 64'(DIV_40 - 1)) / 64'(DIV_40));
   localparam logic [RECIP_W-1:0] RECIP_34 =
      RECIP_W'((RECIP_ONE + 64'(DIV_34 - 1)) / 64'(DIV_34));
   localparam logic [RECIP_W-1:0] RECIP_29 =
      RECIP_W'((RECIP_ONE + 64'(DIV_29 - 1)) / 64'(DIV_29));
   localparam logic [RECIP_W-1:0] RECIP_20 =
      RECIP_W'((RECIP_ONE + 64'(DIV_20 - 1)) / 64'(DIV_20));

   localparam logic [HALF_W-1:0] HALF_40 = HALF_W'(DIV_40 / 2);
   localparam logic [HALF_W-1:0] HALF_34 = HALF_W'(DIV_34 / 2);
   localparam logic [HALF_W-1:0] HALF_29 = HALF_W'(DIV_29 / 2);
   localparam logic [HALF_W-1:0] HALF_20 = HALF_W'(DIV_20 / 2);

   typedef logic [NUM_CH-1:0][CH_W-1:0] pix_type;
   // index 0 is the newest row of a column, index 2 the oldest
   typedef pix_type [LINE_ROWS-1:0] line_word_type;

   typedef struct packed {
      logic [KERN_N-1:0][PART_W-1:0] outer;
      logic [KERN_N-1:0][PART_W-1:0] inner;
   } chan_part_type;

   typedef chan_part_type [NUM_CH-1:0] part_type;

   typedef struct packed {
      logic              row_shift;
      logic              col_shift;
      logic [KERN_N-1:0] row_keep;
      logic [KERN_N-1:0] col_keep;
   } win_ctrl_type;

   typedef struct packed {
      den_code_type den;
      logic         done;
   } filt_tag_type;

   typedef struct packed {
      logic         go;
      win_ctrl_type win;
      filt_tag_type tag;
   } tap_ctrl_type;

   function automatic logic [RECIP_W-1:0] den_recip(input den_code_type code);
      logic [RECIP_W-1:0] r;
      case (code)
         DEN_40:  r = RECIP_40;
         DEN_34:  r = RECIP_34;
         DEN_29:  r = RECIP_29;
         DEN_20:  r = RECIP_20;
         default: r = RECIP_40;
      endcase
      return r;
   endfunction

   function automatic logic [HALF_W-1:0] den_half(input den_code_type code);
      logic [HALF_W-1:0] h;
      case (code)
         DEN_40:  h = HALF_40;
         DEN_34:  h = HALF_34;
         DEN_29:  h = HALF_29;
         DEN_20:  h = HALF_20;
         default: h = HALF_40;
      endcase
      return h;
   endfunction

endpackage

// ===== src/mds_line_mem.sv =====
// column-indexed line store holding the last three source rows
`timescale 1ns / 1ps
module mds_line_mem #(
   parameter int ADDR_W = 8
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output mds_pkg::line_word_type rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  mds_pkg::line_word_type wr_data
);
   import mds_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   line_word_type mem [DEPTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mds_window.sv =====
// 4x4 tap window: edge shift, tap masking and per-column partial sums
`timescale 1ns / 1ps
module mds_window (
   input  logic                   clock,
   input  logic                   shift_en,
   input  mds_pkg::pix_type       cur_pix,
   input  mds_pkg::line_word_type col_rows,
   input  mds_pkg::win_ctrl_type  ctrl,
   output mds_pkg::part_type      part
);
   import mds_pkg::*;

   pix_type win_ff [KERN_N][WIN_COLS];
   pix_type newest [KERN_N];
   pix_type taps   [KERN_N][KERN_N];
   pix_type rsel   [KERN_N][KERN_N];
   pix_type csel   [KERN_N][KERN_N];
   pix_type kept   [KERN_N][KERN_N];

   // newest column, oldest row first
   always_comb begin
      newest[0] = col_rows[2];
      newest[1] = col_rows[1];
      newest[2] = col_rows[0];
      newest[3] = cur_pix;
   end

   always_comb begin
      for (int k = 0; k < KERN_N; k++) begin
         for (int m = 0; m < WIN_COLS; m++) begin
            taps[k][m] = win_ff[k][m];
         end
         taps[k][KERN_N-1] = newest[k];
      end
   end

   // last row or column of the image: window slides one tap toward the newest
   always_comb begin
      for (int m = 0; m < KERN_N; m++) begin
         for (int k = 0; k < KERN_N - 1; k++) begin
            rsel[k][m] = ctrl.row_shift ? taps[k+1][m] : taps[k][m];
         end
         rsel[KERN_N-1][m] = taps[KERN_N-1][m];
      end
      for (int k = 0; k < KERN_N; k++) begin
         for (int m = 0; m < KERN_N - 1; m++) begin
            csel[k][m] = ctrl.col_shift ? rsel[k][m+1] : rsel[k][m];
         end
         csel[k][KERN_N-1] = rsel[k][KERN_N-1];
      end
      for (int k = 0; k < KERN_N; k++) begin
         for (int m = 0; m < KERN_N; m++) begin
            kept[k][m] = (ctrl.row_keep[k] && ctrl.col_keep[m]) ? csel[k][m] : '0;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int m = 0; m < KERN_N; m++) begin
            part[ch].outer[m] = PART_W'(kept[0][m][ch]) + PART_W'(kept[3][m][ch]);
            part[ch].inner[m] = PART_W'(kept[1][m][ch]) + PART_W'(kept[2][m][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int k = 0; k < KERN_N; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
            win_ff[k][2] <= newest[k];
         end
      end
   end

endmodule

// ===== src/mds_filter.sv =====
// weighted sum, rounding and reciprocal normalize pipeline with output register
`timescale 1ns / 1ps
module mds_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mds_pkg::part_type     in_part,
   input  mds_pkg::filt_tag_type in_tag,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mds_pkg::pix_type      out_pix,
   output logic                  out_done
);
   import mds_pkg::*;

   logic v2_ff, v3_ff, v4_ff, v5_ff, out_valid_ff;
   logic rdy2, rdy3, rdy4, rdy5, rdy_out;

   part_type     part2_ff;
   filt_tag_type tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   logic [NUM_CH-1:0][SUM_W-1:0] soo3_ff, soi3_ff, sio3_ff, sii3_ff;
   logic [NUM_CH-1:0][SUM_W-1:0] soo3_in, soi3_in, sio3_in, sii3_in;
   logic [NUM_CH-1:0][ACC_W-1:0] a4_ff, b4_ff, a4_in, b4_in;
   logic [NUM_CH-1:0][ACC_W-1:0] x5_ff, x5_in;
   logic [NUM_CH-1:0][PROD_W-1:0] prod;
   logic [RECIP_W-1:0] recip;
   pix_type out_pix_ff, out_pix_in;
   logic    out_done_ff;

   // each stage moves when it is empty or the next one moves
   always_comb begin
      rdy_out  = !out_valid_ff || out_ready;
      rdy5     = !v5_ff || rdy_out;
      rdy4     = !v4_ff || rdy5;
      rdy3     = !v3_ff || rdy4;
      rdy2     = !v2_ff || rdy3;
      in_ready = rdy2;
   end

   always_comb begin
      recip = den_recip(tag5_ff.den);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         // outer/inner rows against outer/inner columns
         soo3_in[ch] = SUM_W'(part2_ff[ch].outer[0]) + SUM_W'(part2_ff[ch].outer[3]);
         soi3_in[ch] = SUM_W'(part2_ff[ch].inner[0]) + SUM_W'(part2_ff[ch].inner[3]);
         sio3_in[ch] = SUM_W'(part2_ff[ch].outer[1]) + SUM_W'(part2_ff[ch].outer[2]);
         sii3_in[ch] = SUM_W'(part2_ff[ch].inner[1]) + SUM_W'(part2_ff[ch].inner[2]);
         // weights 1, 2, 2, 5
         a4_in[ch] = ACC_W'(soo3_ff[ch]) + (ACC_W'(soi3_ff[ch]) << 1);
         b4_in[ch] = (ACC_W'(sio3_ff[ch]) << 1) + (ACC_W'(sii3_ff[ch]) << 2)
                     + ACC_W'(sii3_ff[ch]);
         x5_in[ch] = a4_ff[ch] + b4_ff[ch] + ACC_W'(den_half(tag4_ff.den));
         prod[ch]  = PROD_W'(x5_ff[ch]) * PROD_W'(recip);
         out_pix_in[ch] = prod[ch][RECIP_SHIFT +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy_out) begin
            out_valid_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         part2_ff <= in_part;
         tag2_ff  <= in_tag;
      end
      if (rdy3) begin
         soo3_ff <= soo3_in;
         soi3_ff <= soi3_in;
         sio3_ff <= sio3_in;
         sii3_ff <= sii3_in;
         tag3_ff <= tag2_ff;
      end
      if (rdy4) begin
         a4_ff   <= a4_in;
         b4_ff   <= b4_in;
         tag4_ff <= tag3_ff;
      end
      if (rdy5) begin
         x5_ff   <= x5_in;
         tag5_ff <= tag4_ff;
      end
      if (rdy_out) begin
         out_pix_ff  <= out_pix_in;
         out_done_ff <= tag5_ff.done;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pix   = out_pix_ff;
   assign out_done  = out_done_ff;

endmodule

// ===== src/mipmap_downsample_4x4.sv =====
// top level of the 4x4 weighted mipmap downsampler
`timescale 1ns / 1ps
//
//  channel   ports                          direction  moves
//  req       req_valid/req_ready, req_in_*  in         one source pixel, raster order
//  rsp       rsp_valid/rsp_ready, rsp_*     out        one half-size pixel + image_done
//  csr       csr_wr_en, csr_wr_data         in         source_size_log2, no wait state
//
//  one source pixel per cycle sustained while the rsp side drains; the line store is read once at
//  acceptance and written back once as the pixel leaves stage 1, on separate read and write ports, so it keeps pace
//  a result is registered in stage 1, then in the filter pipeline stages and its output register
//  synchronous active-high reset clears counters, size (to 8) and all valid bits;
//  line store and tap window are not cleared, so there is no clearing pass
//  a stalled rsp side holds only result-carrying stages; pixels that give no result
//  keep flowing until five results are queued behind the output register
//
module mipmap_downsample_4x4 #(
   parameter int MAX_SOURCE_SIZE = mds_pkg::DEFAULT_MAX_SOURCE_SIZE
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mds_pkg::CH_W-1:0]   req_in_red,
   input  logic [mds_pkg::CH_W-1:0]   req_in_green,
   input  logic [mds_pkg::CH_W-1:0]   req_in_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mds_pkg::CH_W-1:0]   rsp_out_red,
   output logic [mds_pkg::CH_W-1:0]   rsp_out_green,
   output logic [mds_pkg::CH_W-1:0]   rsp_out_blue,
   output logic                       rsp_image_done,
   input  logic                       csr_wr_en,
   input  logic [mds_pkg::CSR_W-1:0]  csr_wr_data
);
   import mds_pkg::*;

   // largest power-of-two side that fits
   localparam int LG_MAX = $clog2(MAX_SOURCE_SIZE + 1) - 1;
   localparam int POS_W  = LG_MAX;
   localparam logic [CSR_W-1:0] LG_MAX_CODE = CSR_W'(LG_MAX);

   // size register and raster position of the next source pixel
   logic [CSR_W-1:0] size_log2_ff;
   logic [POS_W-1:0] row_ff, col_ff, row_in, col_in;

   logic [CSR_W-1:0] lg_eff;
   logic [POS_W:0]   side;
   logic [POS_W-1:0] last_pos;
   logic [POS_W-1:0] row_cur, col_cur;
   logic             row_last, col_last, row_two, col_two;
   logic             row_go, col_go, row_drop, col_drop, narrow;
   tap_ctrl_type     ctrl_in;
   logic             req_fire;

   // stage 1: pixel waits here while its column comes out of the line store
   logic             s1_valid_ff;
   pix_type          s1_pix_ff;
   logic [POS_W-1:0] s1_col_ff;
   tap_ctrl_type     s1_ctrl_ff;
   logic             s1_fire;

   pix_type       cur_pix;
   line_word_type line_rd, line_wr;
   part_type      part;
   logic          filt_ready;
   pix_type       rsp_pix;

   assign cur_pix[CH_RED]   = req_in_red;
   assign cur_pix[CH_GREEN] = req_in_green;
   assign cur_pix[CH_BLUE]  = req_in_blue;

   // side clamps to 2 at the low end and to the store size at the high end
   always_comb begin
      if (size_log2_ff == '0) begin
         lg_eff = CSR_W'(1);
      end else if (size_log2_ff > LG_MAX_CODE) begin
         lg_eff = LG_MAX_CODE;
      end else begin
         lg_eff = size_log2_ff;
      end
      side     = (POS_W+1)'(1) << lg_eff;
      last_pos = POS_W'(side - (POS_W+1)'(1));
      narrow   = (lg_eff == CSR_W'(1));
   end

   // window position decode for the pixel being accepted
   always_comb begin
      // a position past the side restarts at zero
      row_cur  = ((row_ff & ~last_pos) != '0) ? '0 : row_ff;
      col_cur  = ((col_ff & ~last_pos) != '0) ? '0 : col_ff;
      row_last = (row_cur == last_pos);
      col_last = (col_cur == last_pos);
      row_two  = ({1'b0, row_cur} == (POS_W+1)'(2));
      col_two  = ({1'b0, col_cur} == (POS_W+1)'(2));
      // an output falls due on even positions from 2 and on the last one
      row_go   = row_last || (({1'b0, row_cur} >= (POS_W+1)'(2)) && !row_cur[0]);
      col_go   = col_last || (({1'b0, col_cur} >= (POS_W+1)'(2)) && !col_cur[0]);
      // one outer tap row/column falls off the image at each edge
      row_drop = row_two || row_last;
      col_drop = col_two || col_last;

      ctrl_in.go            = row_go && col_go;
      ctrl_in.win.row_shift = row_last;
      ctrl_in.win.col_shift = col_last;
      ctrl_in.win.row_keep  = {!row_last, 1'b1, 1'b1, !(row_two || narrow)};
      ctrl_in.win.col_keep  = {!col_last, 1'b1, 1'b1, !(col_two || narrow)};
      ctrl_in.tag.done      = row_last && col_last;
      // 2x2 source: both outer rows and columns are gone
      if (narrow) begin
         ctrl_in.tag.den = DEN_20;
      end else begin
         case ({row_drop, col_drop})
            2'b00:   ctrl_in.tag.den = DEN_40;
            2'b01:   ctrl_in.tag.den = DEN_34;
            2'b10:   ctrl_in.tag.den = DEN_34;
            2'b11:   ctrl_in.tag.den = DEN_29;
            default: ctrl_in.tag.den = DEN_40;
         endcase
      end

      col_in = col_last ? '0 : col_cur + POS_W'(1);
      if (col_last) begin
         row_in = row_last ? '0 : row_cur + POS_W'(1);
      end else begin
         row_in = row_cur;
      end
   end

   // stage 1 leaves when it carries no result or the filter takes it
   assign s1_fire   = s1_valid_ff && (!s1_ctrl_ff.go || filt_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (csr_wr_en) begin
         // new size starts a new image
         size_log2_ff <= csr_wr_data;
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (req_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= cur_pix;
         s1_col_ff  <= col_cur;
         s1_ctrl_ff <= ctrl_in;
      end
   end

   // write-back ages the column by one row; the next access to the same column is
   // at least two transactions later, after this write, so no forwarding is needed
   always_comb begin
      line_wr[0] = s1_pix_ff;
      line_wr[1] = line_rd[0];
      line_wr[2] = line_rd[1];
   end

   mds_line_mem #(
      .ADDR_W (POS_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_cur),
      .rd_data (line_rd),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr)
   );

   mds_window u_window (
      .clock    (clock),
      .shift_en (s1_fire),
      .cur_pix  (s1_pix_ff),
      .col_rows (line_rd),
      .ctrl     (s1_ctrl_ff.win),
      .part     (part)
   );

   mds_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff && s1_ctrl_ff.go),
      .in_ready  (filt_ready),
      .in_part   (part),
      .in_tag    (s1_ctrl_ff.tag),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pix   (rsp_pix),
      .out_done  (rsp_image_done)
   );

   assign rsp_out_red   = rsp_pix[CH_RED];
   assign rsp_out_green = rsp_pix[CH_GREEN];
   assign rsp_out_blue  = rsp_pix[CH_BLUE];

endmodule

// ===== src/mds_checker.sv =====
// port-level assertion checker for the mipmap downsampler, bound to the top level
`timescale 1ns / 1ps
module mds_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [mds_pkg::CH_W-1:0]  req_in_red,
   input logic [mds_pkg::CH_W-1:0]  req_in_green,
   input logic [mds_pkg::CH_W-1:0]  req_in_blue,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [mds_pkg::CH_W-1:0]  rsp_out_red,
   input logic [mds_pkg::CH_W-1:0]  rsp_out_green,
   input logic [mds_pkg::CH_W-1:0]  rsp_out_blue,
   input logic                      rsp_image_done,
   input logic                      csr_wr_en,
   input logic [mds_pkg::CSR_W-1:0] csr_wr_data
);

   // a stalled result transaction keeps its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_image_done))
      else $error("rsp transaction changed while stalled");

   // a stalled source transaction keeps its payload
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_red)
         && $stable(req_in_green) && $stable(req_in_blue))
      else $error("req transaction changed while stalled");

   // with the output side free, nothing inside may hold back the input
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while rsp side can drain");

   // size writes land only while both channels are quiet
   a_csr_idle : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !req_valid && !rsp_valid && !$isunknown(csr_wr_data))
      else $error("size write while transactions in flight");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind mipmap_downsample_4x4 mds_checker u_mds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_in_red     (req_in_red),
   .req_in_green   (req_in_green),
   .req_in_blue    (req_in_blue),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_red    (rsp_out_red),
   .rsp_out_green  (rsp_out_green),
   .rsp_out_blue   (rsp_out_blue),
   .rsp_image_done (rsp_image_done),
   .csr_wr_en      (csr_wr_en),
   .csr_wr_data    (csr_wr_data)
);

// ===== dv/tb.sv =====
// self-checking testbench for the 4x4 weighted mipmap downsampler
`timescale 1ns / 1ps

module tb;
   import mds_pkg::*;

   localparam int MAX_SIDE      = DEFAULT_MAX_SOURCE_SIZE;
   localparam int IDLE_PCT      = 36;
   // room for results to leave after their last pixel, and for pixels that make no result too
   localparam int SETTLE_CYCLES = 16;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int RAND_ITEMS    = 1650;

   typedef enum logic [1:0] {OP_PIXEL, OP_SIZE_WRITE, OP_DRAIN} stim_kind_type;

   // one entry of the stimulus script: a pixel, a size write, or a pause until drained
   typedef struct packed {
      stim_kind_type     kind;
      logic              hurry;
      logic [CSR_W-1:0]  log2;
      pix_type           px;
   } stim_op_type;

   typedef struct packed {
      pix_type px;
      logic    done;
   } half_px_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CH_W-1:0]   req_in_red = '0;
   logic [CH_W-1:0]   req_in_green = '0;
   logic [CH_W-1:0]   req_in_blue = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CH_W-1:0]   rsp_out_red;
   logic [CH_W-1:0]   rsp_out_green;
   logic [CH_W-1:0]   rsp_out_blue;
   logic              rsp_image_done;
   logic              csr_wr_en = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   mipmap_downsample_4x4 #(
      .MAX_SOURCE_SIZE (MAX_SIDE)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_image_done (rsp_image_done),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // filter predictor state: its own copy of the size register, counters and stores
   // ---------------------------------------------------------------------------------------
   logic [CSR_W-1:0]  size_log2 = SIZE_LOG2_RESET;
   int unsigned       row_pos = 0;
   int unsigned       col_pos = 0;
   pix_type           line_mem [0:LINE_ROWS*MAX_SIDE-1];
   pix_type           col_win [0:KERN_N-1][0:WIN_COLS-1];

   half_px_type       half_px_q [$];     // filtered pixels still owed by the block
   stim_op_type       stim_q [$];        // script the driver works through
   logic              results_pending = 1'b0;
   logic              steady = 1'b0;     // no idling on either side while set
   int unsigned       settle_cnt = 0;

   int unsigned       mismatch_count = 0;
   int unsigned       pixels_in = 0;
   int unsigned       half_px_checked = 0;
   int unsigned       images_done = 0;
   logic [15:0]       size_codes = '0;

   // side length for a size code: 0 acts as 1, oversize halves down to the store width
   function automatic int unsigned side_of(input logic [CSR_W-1:0] code);
      int unsigned n;
      n = 1 << ((code == 0) ? 1 : code);
      while (n > MAX_SIDE && n > 2)
         n = n >> 1;
      return n;
   endfunction

   // one source pixel in; queues the half-size pixel it completes, if any
   function automatic void downsample_step(input pix_type px);
      int unsigned n, half, r, c, oi, oj, rs, cs, den, w;
      pix_type     taps [0:KERN_N-1][0:KERN_N-1];
      logic [63:0] acc [0:NUM_CH-1];
      logic        rlast, clast, keep_row, keep_col;
      half_px_type res;
      n = side_of(size_log2);
      half = n / 2;
      r = (row_pos >= n) ? 0 : row_pos;
      c = (col_pos >= n) ? 0 : col_pos;

      // window is rows r-3..r and columns c-3..c; newest column comes from the line store
      for (int k = 0; k < LINE_ROWS; k++)
         taps[k][KERN_N-1] = line_mem[((r + k) % LINE_ROWS) * MAX_SIDE + c];
      taps[KERN_N-1][KERN_N-1] = px;
      for (int k = 0; k < KERN_N; k++)
         for (int m = 0; m < WIN_COLS; m++)
            taps[k][m] = col_win[k][m];

      line_mem[(r % LINE_ROWS) * MAX_SIDE + c] = px;
      for (int k = 0; k < KERN_N; k++) begin
         col_win[k][0] = col_win[k][1];
         col_win[k][1] = col_win[k][2];
         col_win[k][2] = taps[k][KERN_N-1];
      end

      rlast = (r == n - 1);
      clast = (c == n - 1);
      if ((rlast || (r >= 2 && r % 2 == 0)) && (clast || (c >= 2 && c % 2 == 0))) begin
         oi = rlast ? half - 1 : r / 2 - 1;
         oj = clast ? half - 1 : c / 2 - 1;
         // on the last row or column the window sits one step further on
         rs = rlast ? 1 : 0;
         cs = clast ? 1 : 0;
         den = 0;
         for (int ch = 0; ch < NUM_CH; ch++)
            acc[ch] = '0;
         for (int k = 0; k < KERN_N; k++) begin
            keep_row = !((k == 0 && oi == 0) || (k == 3 && oi == half - 1) || k + rs > 3);
            for (int m = 0; m < KERN_N; m++) begin
               keep_col = !((m == 0 && oj == 0) || (m == 3 && oj == half - 1) || m + cs > 3);
               if (keep_row && keep_col) begin
                  // kernel 1 2 2 1 / 2 5 5 2 / 2 5 5 2 / 1 2 2 1
                  if ((k == 0 || k == 3) && (m == 0 || m == 3))
                     w = 1;
                  else if (k == 0 || k == 3 || m == 0 || m == 3)
                     w = 2;
                  else
                     w = 5;
                  den += w;
                  for (int ch = 0; ch < NUM_CH; ch++)
                     acc[ch] = acc[ch] + 64'(w) * 64'(taps[k + rs][m + cs][ch]);
               end
            end
         end
         // round to nearest, ties up
         for (int ch = 0; ch < NUM_CH; ch++)
            res.px[ch] = CH_W'((acc[ch] + 64'(den / 2)) / 64'(den));
         res.done = rlast && clast;
         half_px_q.push_back(res);
      end

      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n)
            r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------------------
   // script building
   // ---------------------------------------------------------------------------------------
   function automatic pix_type rgb(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                                   input logic [CH_W-1:0] blue);
      pix_type p;
      p[CH_RED]   = red;
      p[CH_GREEN] = green;
      p[CH_BLUE]  = blue;
      return p;
   endfunction

   // mostly full-range, with the ends of the range and small values for rounding
   function automatic logic [CH_W-1:0] rand_channel();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2, 3:    return CH_W'($urandom_range(0, 63));
         default: return CH_W'($urandom);
      endcase
   endfunction

   task automatic add_pixel(input pix_type px, input logic hurry);
      stim_op_type op;
      op = '0;
      op.kind  = OP_PIXEL;
      op.hurry = hurry;
      op.px    = px;
      stim_q.push_back(op);
   endtask

   task automatic add_drain();
      stim_op_type op;
      op = '0;
      op.kind = OP_DRAIN;
      stim_q.push_back(op);
   endtask

   // size changes only once the block has gone quiet
   task automatic add_size(input logic [CSR_W-1:0] code);
      stim_op_type op;
      add_drain();
      op = '0;
      op.kind = OP_SIZE_WRITE;
      op.log2 = code;
      stim_q.push_back(op);
   endtask

   // ---------------------------------------------------------------------------------------
   // driver: one script entry at a time, holding valid and payload until accepted
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      stim_op_type op;
      logic        next_valid, next_wr;
      if (!reset && !(req_valid && !req_ready)) begin
         next_valid = 1'b0;
         next_wr    = 1'b0;
         if (settle_cnt != 0) begin
            settle_cnt--;
         end else if (stim_q.size() != 0) begin
            op = stim_q[0];
            case (op.kind)
               OP_PIXEL: begin
                  steady <= op.hurry;
                  if (op.hurry || $urandom_range(0, 99) >= IDLE_PCT) begin
                     void'(stim_q.pop_front());
                     req_in_red   <= op.px[CH_RED];
                     req_in_green <= op.px[CH_GREEN];
                     req_in_blue  <= op.px[CH_BLUE];
                     next_valid = 1'b1;
                  end
               end
               OP_SIZE_WRITE: begin
                  void'(stim_q.pop_front());
                  csr_wr_data <= op.log2;
                  next_wr = 1'b1;
               end
               OP_DRAIN: begin
                  // skip the edge a transaction went through; the pending flag is registered and lags
                  if (!req_valid && !results_pending) begin
                     void'(stim_q.pop_front());
                     settle_cnt = SETTLE_CYCLES;
                  end
               end
               default: begin
                  void'(stim_q.pop_front());
               end
            endcase
         end
         req_valid <= next_valid;
         csr_wr_en <= next_wr;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------------------------
   // monitor: check results first, then apply size writes and predict for new pixels
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      half_px_type want;
      pix_type     px_in;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            half_px_checked++;
            if (rsp_image_done === 1'b1)
               images_done++;
            if (half_px_q.size() == 0) begin
               log_mismatch($sformatf("unexpected result r=%06h g=%06h b=%06h done=%0b",
                  rsp_out_red, rsp_out_green, rsp_out_blue, rsp_image_done));
            end else begin
               want = half_px_q.pop_front();
               if (rsp_out_red !== want.px[CH_RED] || rsp_out_green !== want.px[CH_GREEN] ||
                   rsp_out_blue !== want.px[CH_BLUE] || rsp_image_done !== want.done)
                  log_mismatch($sformatf(
                     "exp r=%06h g=%06h b=%06h done=%0b got r=%06h g=%06h b=%06h done=%0b",
                     want.px[CH_RED], want.px[CH_GREEN], want.px[CH_BLUE], want.done,
                     rsp_out_red, rsp_out_green, rsp_out_blue, rsp_image_done));
            end
         end
         if (csr_wr_en) begin
            // a size write restarts the image
            size_log2 = csr_wr_data;
            row_pos = 0;
            col_pos = 0;
            size_codes[csr_wr_data] = 1'b1;
         end
         if (req_valid && req_ready) begin
            px_in[CH_RED]   = req_in_red;
            px_in[CH_GREEN] = req_in_green;
            px_in[CH_BLUE]  = req_in_blue;
            downsample_step(px_in);
            pixels_in++;
         end
      end
      results_pending <= (half_px_q.size() != 0);
   end

   // watchdog on transactions in either direction
   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, half_px_q.size());
            $display("mipmap_downsample_4x4: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned      side, count, n_rand, phase;
      logic [CSR_W-1:0] code;
      logic             hurry;
      pix_type          px;

      // smallest image, all channels at full scale: result must not overflow
      add_size(4'd1);
      for (int i = 0; i < 4; i++)
         add_pixel(rgb('1, '1, '1), 1'b0);
      // code 0 behaves as the smallest size
      add_size(4'd0);
      add_pixel(rgb('0, '1, 24'd1), 1'b0);
      add_pixel(rgb('1, '0, 24'd2), 1'b0);
      add_pixel(rgb(24'd1, '1, '0), 1'b0);
      add_pixel(rgb('1, 24'd1, 24'd3), 1'b0);
      // 4x4 image: corner pixels with edge taps dropped on every side
      add_size(4'd2);
      for (int i = 0; i < 16; i++)
         add_pixel(rgb((i % 2 != 0) ? '1 : '0, CH_W'(24'h111111 * i),
                       (i % 5 == 0) ? '1 : CH_W'(i)), 1'b0);

      // random phases: back-to-back images at small sizes, partial images at large ones
      n_rand = 0;
      phase = 0;
      while (n_rand < RAND_ITEMS || phase < 4) begin
         hurry = 1'b0;
         if (phase == 1) begin
            // full-width rows at the default size, one result row, no idling
            code  = 4'd8;
            count = 3 * MAX_SIDE + $urandom_range(0, 15);
            hurry = 1'b1;
         end else if (phase == 3) begin
            // oversize code clamps to the store width
            code  = CSR_W'($urandom_range(9, 15));
            count = 2 * MAX_SIDE + $urandom_range(2, 40);
         end else begin
            code = ($urandom_range(1, 100) <= 85) ? CSR_W'($urandom_range(0, 4))
                                                  : CSR_W'($urandom_range(5, 7));
            side = side_of(code);
            if (side <= 16) begin
               count = $urandom_range(1, (side <= 4) ? 4 : 1) * side * side;
               // sometimes leave the last image unfinished before the next size change
               if ($urandom_range(0, 1) != 0)
                  count += $urandom_range(0, side * side - 1);
            end else begin
               count = $urandom_range(2 * side, 4 * side);
            end
         end
         add_size(code);
         for (int i = 0; i < count; i++) begin
            for (int ch = 0; ch < NUM_CH; ch++)
               px[ch] = rand_channel();
            add_pixel(px, hurry);
            if ($urandom_range(0, 199) == 0)
               add_drain();
         end
         n_rand += count;
         phase++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sample at the falling edge so every update of the rising edge has landed
      do
         @(negedge clock);
      while (stim_q.size() != 0 || req_valid || csr_wr_en || settle_cnt != 0 ||
             results_pending);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (half_px_q.size() != 0)
         log_mismatch($sformatf("%0d expected results never arrived", half_px_q.size()));

      $display("%0d source pixels in, %0d half-size pixels checked, %0d images completed",
               pixels_in, half_px_checked, images_done);
      $display("%0d of 16 size codes written, %0d mismatches", $countones(size_codes),
               mismatch_count);
      if (mismatch_count == 0)
         $display("mipmap_downsample_4x4: match");
      else
         $display("mipmap_downsample_4x4: mismatch");
      $finish;
   end

endmodule
